@@ sv/blr_pkg.sv @@
// Shared types, constants and helpers for the bitmap line rasterizer.
// No dependencies; imported by the rasterizer top level and its checker.
package blr_pkg;

  // Screen geometry; a character cell is 8x8 pixels, one byte per cell row
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;

  localparam int COL_W  = 9;
  localparam int ROW_W  = 8;
  localparam int ADDR_W = 16;
  localparam int MASK_W = 8;
  localparam int ERR_W  = 11;

  typedef logic [COL_W-1:0]        col_t;
  typedef logic [ROW_W-1:0]        row_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [MASK_W-1:0]       mask_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // Drawing path of the current line
  typedef enum logic [1:0] {
    PATH_IDLE = 2'd0,
    PATH_HORZ = 2'd1,
    PATH_VERT = 2'd2,
    PATH_BRES = 2'd3
  } path_t;

  // Input mode codes
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // One masked byte write
  typedef struct packed {
    addr_t addr;
    mask_t mask;
    logic  set;
    logic  done;
  } result_t;

  // Byte offset of a pixel in cell order: row band, cell column, row in cell
  function automatic addr_t cell_offset(col_t c, row_t r);
    addr_t band;
    band = ADDR_W'(SCREEN_WIDTH) * ADDR_W'(r[ROW_W-1:3]);
    return band + ADDR_W'({c[COL_W-1:3], 3'b000}) + ADDR_W'(r[2:0]);
  endfunction

endpackage

@@ sv/bitmap_line_rasterizer.sv @@
// Line rasterizer top level: line state registers, write generation, output skid.
// Depends on blr_pkg.
// An accepted advance item registers its write in the output stage, or in the skid stage.
// Throughput: one item per cycle while in_stall is low; a start item loads the line state and yields no write.
// A write pushed while the output holds a stalled write parks in a one-entry skid stage;
// in_stall then holds the input while the skid drains.
// Reset (synchronous, rst_n low): path idle, line state and bitmap base zero, output empty.
module bitmap_line_rasterizer (
  input  logic          clk,
  input  logic          rst_n,
  // input item channel
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_mode,
  input  blr_pkg::col_t in_start_x,
  input  blr_pkg::row_t in_start_y,
  input  blr_pkg::col_t in_end_x,
  input  blr_pkg::row_t in_end_y,
  input  logic          in_draw_set,
  // result item channel
  output logic           out_valid,
  input  logic           out_stall,
  output blr_pkg::addr_t out_write_address,
  output blr_pkg::mask_t out_write_mask,
  output logic           out_write_set,
  output logic           out_line_done,
  // configuration: bitmap base
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  blr_pkg::addr_t cfg_data
);
  import blr_pkg::*;

  // line state
  addr_t base_r;
  path_t path_r, path_nxt;
  col_t  cur_col_r, cur_col_nxt, goal_col_r, goal_col_nxt, dcol_r, dcol_nxt;
  row_t  cur_row_r, cur_row_nxt, goal_row_r, goal_row_nxt;
  logic [ROW_W-1:0] drow_r, drow_nxt;
  logic  col_neg_r, col_neg_nxt, row_neg_r, row_neg_nxt;
  err_t  err_r, err_nxt;
  logic  set_r, set_nxt;

  // output stage
  logic    out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  result_t out_data_r, skid_data_r;

  logic    accept, push, take;
  result_t res;
  logic    step_col, step_row;

  // start decode
  logic x_lt, y_lt;
  col_t abs_dc;
  row_t abs_dr;

  // bresenham compare operands
  logic signed [ERR_W:0] e_ext, neg_dc, pos_dr, e_upd;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid & ~in_stall;
  assign push      = accept & (in_mode == MODE_ADVANCE) & (path_r != PATH_IDLE);
  assign take      = out_valid_r & ~out_stall;

  // bresenham step decisions from the registered error term
  assign e_ext    = {err_r[ERR_W-1], err_r};
  assign neg_dc   = (ERR_W+1)'(0) - (ERR_W+1)'(dcol_r);
  assign pos_dr   = (ERR_W+1)'(drow_r);
  assign step_col = e_ext > neg_dc;
  assign step_row = e_ext < pos_dr;

  // write for the current pixel or span byte
  always_comb begin
    res      = '0;
    res.set  = set_r;
    res.addr = base_r + cell_offset(cur_col_r, cur_row_r);
    unique case (path_r)
      PATH_HORZ: begin
        res.mask = 8'hff >> cur_col_r[2:0];
        if (cur_col_r[COL_W-1:3] == goal_col_r[COL_W-1:3]) begin
          res.mask = res.mask & (8'hff << (3'd7 - goal_col_r[2:0]));
          res.done = 1'b1;
        end
      end
      PATH_VERT: begin
        res.mask = 8'h80 >> cur_col_r[2:0];
        res.done = cur_row_r == goal_row_r;
      end
      PATH_BRES: begin
        res.mask = 8'h80 >> cur_col_r[2:0];
        res.done = (cur_col_r == goal_col_r) && (cur_row_r == goal_row_r);
      end
      default: begin
        res.mask = '0;
      end
    endcase
  end

  // start operand decode
  always_comb begin
    x_lt   = in_start_x < in_end_x;
    y_lt   = in_start_y < in_end_y;
    abs_dc = x_lt ? in_end_x - in_start_x : in_start_x - in_end_x;
    abs_dr = y_lt ? in_end_y - in_start_y : in_start_y - in_end_y;
  end

  // next line state: start loads, advance steps
  always_comb begin
    path_nxt     = path_r;
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    goal_col_nxt = goal_col_r;
    goal_row_nxt = goal_row_r;
    dcol_nxt     = dcol_r;
    drow_nxt     = drow_r;
    col_neg_nxt  = col_neg_r;
    row_neg_nxt  = row_neg_r;
    err_nxt      = err_r;
    set_nxt      = set_r;
    e_upd        = e_ext;
    if (accept && in_mode == MODE_START) begin
      set_nxt     = in_draw_set;
      dcol_nxt    = abs_dc;
      drow_nxt    = abs_dr;
      col_neg_nxt = ~x_lt;
      row_neg_nxt = ~y_lt;
      if (in_start_y == in_end_y) begin
        path_nxt     = PATH_HORZ;
        cur_col_nxt  = x_lt ? in_start_x : in_end_x;
        goal_col_nxt = x_lt ? in_end_x : in_start_x;
        cur_row_nxt  = in_start_y;
        goal_row_nxt = in_start_y;
      end else if (in_start_x == in_end_x) begin
        path_nxt     = PATH_VERT;
        cur_row_nxt  = y_lt ? in_start_y : in_end_y;
        goal_row_nxt = y_lt ? in_end_y : in_start_y;
        cur_col_nxt  = in_start_x;
        goal_col_nxt = in_start_x;
      end else begin
        path_nxt     = PATH_BRES;
        cur_col_nxt  = in_start_x;
        cur_row_nxt  = in_start_y;
        goal_col_nxt = in_end_x;
        goal_row_nxt = in_end_y;
        if (abs_dc > COL_W'(abs_dr)) begin
          err_nxt = err_t'({3'b000, abs_dc[COL_W-1:1]});
        end else begin
          err_nxt = err_t'(11'd0 - {4'b0000, abs_dr[ROW_W-1:1]});
        end
      end
    end else if (push) begin
      if (res.done) begin
        path_nxt = PATH_IDLE;
      end else begin
        unique case (path_r)
          PATH_HORZ: cur_col_nxt = {cur_col_r[COL_W-1:3] + 6'd1, 3'b000};
          PATH_VERT: cur_row_nxt = cur_row_r + 8'd1;
          PATH_BRES: begin
            if (step_col) begin
              e_upd       = e_upd - pos_dr;
              cur_col_nxt = col_neg_r ? cur_col_r - 9'd1 : cur_col_r + 9'd1;
            end
            if (step_row) begin
              e_upd       = e_upd - neg_dc;
              cur_row_nxt = row_neg_r ? cur_row_r - 8'd1 : cur_row_r + 8'd1;
            end
            err_nxt = e_upd[ERR_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // output register and skid valid control
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      path_r       <= PATH_IDLE;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      goal_col_r   <= '0;
      goal_row_r   <= '0;
      dcol_r       <= '0;
      drow_r       <= '0;
      col_neg_r    <= 1'b0;
      row_neg_r    <= 1'b0;
      err_r        <= '0;
      set_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_data;
      end
      path_r       <= path_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      goal_col_r   <= goal_col_nxt;
      goal_row_r   <= goal_row_nxt;
      dcol_r       <= dcol_nxt;
      drow_r       <= drow_nxt;
      col_neg_r    <= col_neg_nxt;
      row_neg_r    <= row_neg_nxt;
      err_r        <= err_nxt;
      set_r        <= set_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end
    if (!skid_valid_r) begin
      skid_data_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = out_data_r.addr;
  assign out_write_mask    = out_data_r.mask;
  assign out_write_set     = out_data_r.set;
  assign out_line_done     = out_data_r.done;

endmodule

@@ sv/blr_checker.sv @@
// Port-level checker for the bitmap line rasterizer, with its bind statement.
// Depends on blr_pkg and attaches to bitmap_line_rasterizer.
module blr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input blr_pkg::addr_t out_write_address,
  input blr_pkg::mask_t out_write_mask,
  input logic           out_write_set,
  input logic           out_line_done,
  input logic           cfg_ready
);
  import blr_pkg::*;

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  // input only backs up when a write is already waiting at the output
  a_stall_needs_out: assert property (@(posedge clk) in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // a stalled write stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("write dropped while stalled");

  // a stalled write keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_write_address) && $stable(out_write_mask)
      && $stable(out_write_set) && $stable(out_line_done))
    else $error("write payload changed while stalled");

  // any write carries at least one pixel
  a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cfg_ready |-> out_write_mask != mask_t'(0))
    else $error("write with empty mask");

endmodule

bind bitmap_line_rasterizer blr_checker u_blr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_write_address (out_write_address),
  .out_write_mask    (out_write_mask),
  .out_write_set     (out_write_set),
  .out_line_done     (out_line_done),
  .cfg_ready         (cfg_ready)
);
